FILE: design/ffd_pkg.sv
package ffd_pkg;

	localparam int TEMP_W = 16;
	localparam int CNT_OUT_W = 5;
	localparam int RISE_W = 16;
	localparam int PDATA_W = 32;
	localparam int APB_ADDR_W = 4;
	localparam int REG_IDX_W = APB_ADDR_W - 2;

	typedef logic signed [TEMP_W-1:0] temp_t;

	// Register map, one word per register.
	localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_NEED = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RISE_THR = 2'd2;

	localparam temp_t RST_HIGH_THR = 16'sd58;
	localparam logic [CNT_OUT_W-1:0] RST_COUNT_NEED = 5'd27;
	localparam logic [RISE_W-1:0] RST_RISE_THR = 16'd8;

	typedef struct packed {
		temp_t sample;
	} sample_beat_t;

	typedef struct packed {
		logic alarm;
		logic median_valid;
		temp_t median_value;
		logic fixed_trip;
		logic rise_trip;
		logic [CNT_OUT_W-1:0] high_count;
	} result_beat_t;

	typedef struct packed {
		logic mvalid;
		temp_t median;
		temp_t sample;
	} med_beat_t;

endpackage

FILE: design/ffd_stream_if.sv
interface ffd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/fire_temperature_detector_top.sv
// Channel   | Dir | Beat          | Meaning
// samples   | in  | sample_beat_t | one temperature reading
// results   | out | result_beat_t | alarm, median, trips and high count for that reading
// APB       | in  | 32-bit words  | thresholds and high count needed
//
// One sample is taken every cycle when the result side keeps up; each result
// passes in order through the registered stages window compare, rank select,
// history push, group popcount, and final sum and trip check.
// Each stage holds its beat while the next one is full, so a stalled result
// does not block the stages in front of it until they fill.
// Reset clears every valid bit and the alarm; there is no clearing pass.
module fire_temperature_detector_top #(
	parameter int RAW_WINDOW = 5,
	parameter int HISTORY_DEPTH = 30
) (
	input logic clk,
	input logic arst_n,
	ffd_stream_if.sink samples,
	ffd_stream_if.source results,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ffd_pkg::APB_ADDR_W-1:0] paddr,
	input logic [ffd_pkg::PDATA_W-1:0] pwdata,
	output logic [ffd_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import ffd_pkg::*;

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
	localparam int GRP = 8;
	localparam int GRP_W = $clog2(GRP + 1);
	localparam int NG = (HISTORY_DEPTH + GRP - 1) / GRP;

	// Configuration registers.
	temp_t thr_q;
	logic [CNT_OUT_W-1:0] need_q;
	logic [RISE_W-1:0] rise_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RST_HIGH_THR;
			need_q <= RST_COUNT_NEED;
			rise_q <= RST_RISE_THR;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HIGH_THR: thr_q <= temp_t'(pwdata[TEMP_W-1:0]);
				REG_COUNT_NEED: need_q <= pwdata[CNT_OUT_W-1:0];
				REG_RISE_THR: rise_q <= pwdata[RISE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HIGH_THR: prdata = PDATA_W'($unsigned(thr_q));
			REG_COUNT_NEED: prdata = PDATA_W'(need_q);
			REG_RISE_THR: prdata = PDATA_W'(rise_q);
			default: prdata = '0;
		endcase
	end

	// Median front end: raw window and rank select.
	logic m_valid;
	logic m_ready;
	med_beat_t m_beat;

	ffd_median #(
		.N(RAW_WINDOW)
	) u_median (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.sample(samples.data.sample),
		.out_valid(m_valid),
		.out_ready(m_ready),
		.out_beat(m_beat)
	);

	// Stage control.
	logic v_s3, v_s4, v_s5;
	logic adv3, adv4, adv5;
	logic push;

	assign adv5 = !v_s5 || results.ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign m_ready = adv3;
	assign push = m_valid && adv3 && m_beat.mvalid;

	// History chain; cell 0 holds the newest median.
	temp_t cval [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] cvld;
	logic [HISTORY_DEPTH-1:0] hi;

	for (genvar c = 0; c < HISTORY_DEPTH; c++) begin : g_hist
		if (c == 0) begin : g_head
			ffd_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(push),
				.d(m_beat.median), .d_vld(1'b1), .thr(thr_q),
				.q(cval[c]), .q_vld(cvld[c]), .hi(hi[c])
			);
		end else begin : g_body
			ffd_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(push),
				.d(cval[c-1]), .d_vld(cvld[c-1]), .thr(thr_q),
				.q(cval[c]), .q_vld(cvld[c]), .hi(hi[c])
			);
		end
	end

	// Stage 3: the item whose median was just pushed.
	logic mvalid_s3;
	temp_t med_s3, smp_s3;

	// Stage 4: partial high counts and the rise compare.
	logic [NG*GRP-1:0] hi_pad;
	logic [GRP_W-1:0] grp_s4 [NG];
	logic chk_s4, rise_s4, mvalid_s4;
	temp_t med_s4;
	logic signed [TEMP_W:0] diff;
	logic rise_hit;

	assign hi_pad = (NG * GRP)'(hi);
	assign diff = {smp_s3[TEMP_W-1], smp_s3} - {cval[HISTORY_DEPTH-1][TEMP_W-1],
		cval[HISTORY_DEPTH-1]};
	assign rise_hit = $signed({diff[TEMP_W], diff}) >=
		$signed({{(TEMP_W + 2 - RISE_W){1'b0}}, rise_q});

	// Stage 5: final count, trip checks and the alarm latch.
	logic [CNT_W-1:0] cnt;
	logic [CMP_W-1:0] cnt_cmp;
	logic fixed, rise;
	logic alarm_q;
	result_beat_t res_s5;
	result_beat_t res_nxt;

	always_comb begin
		cnt = '0;
		for (int g = 0; g < NG; g++) begin
			cnt = cnt + CNT_W'(grp_s4[g]);
		end
		cnt_cmp = CMP_W'(cnt);
		fixed = chk_s4 && (cnt_cmp >= CMP_W'(need_q));
		rise = chk_s4 && rise_s4;
		res_nxt.alarm = alarm_q || fixed || rise;
		res_nxt.median_valid = mvalid_s4;
		res_nxt.median_value = mvalid_s4 ? med_s4 : '0;
		res_nxt.fixed_trip = fixed;
		res_nxt.rise_trip = rise;
		res_nxt.high_count = cnt_cmp[CNT_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			alarm_q <= 1'b0;
		end else begin
			if (adv3) begin
				v_s3 <= m_valid;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
			if (adv5) begin
				v_s5 <= v_s4;
			end
			if (v_s4 && adv5) begin
				alarm_q <= res_nxt.alarm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_valid && adv3) begin
			mvalid_s3 <= m_beat.mvalid;
			med_s3 <= m_beat.median;
			smp_s3 <= m_beat.sample;
		end
		if (v_s3 && adv4) begin
			for (int g = 0; g < NG; g++) begin
				grp_s4[g] <= GRP_W'($countones(hi_pad[g*GRP +: GRP]));
			end
			chk_s4 <= mvalid_s3 && cvld[HISTORY_DEPTH-1];
			rise_s4 <= rise_hit;
			mvalid_s4 <= mvalid_s3;
			med_s4 <= med_s3;
		end
		if (v_s4 && adv5) begin
			res_s5 <= res_nxt;
		end
	end

	assign results.valid = v_s5;
	assign results.data = res_s5;

`ifndef ASSERT_OFF
	a_alarm_holds: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_q |=> alarm_q)
		else $error("alarm latch dropped");

	a_trip_sets_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.data.fixed_trip || results.data.rise_trip)
		|-> results.data.alarm)
		else $error("trip reported without alarm");

	a_no_median_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.data.median_valid
		|-> results.data.median_value == '0 && !results.data.fixed_trip
		&& !results.data.rise_trip)
		else $error("result without median carries data");

	a_history_packed: assert property (@(posedge clk) disable iff (!arst_n)
		cvld[HISTORY_DEPTH-1] |-> (&cvld))
		else $error("history valid bits have a gap");
`endif

endmodule

FILE: design/ffd_cell.sv
module ffd_cell (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input ffd_pkg::temp_t d,
	input logic d_vld,
	input ffd_pkg::temp_t thr,
	output ffd_pkg::temp_t q,
	output logic q_vld,
	output logic hi
);
	import ffd_pkg::*;

	temp_t val_q;
	logic vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;
	assign q_vld = vld_q;
	assign hi = vld_q && (val_q >= thr);

endmodule

FILE: design/ffd_median.sv
module ffd_median #(
	parameter int N = 5
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ffd_pkg::temp_t sample,
	output logic out_valid,
	input logic out_ready,
	output ffd_pkg::med_beat_t out_beat
);
	import ffd_pkg::*;

	localparam int RK_W = $clog2(N);
	localparam logic [RK_W-1:0] MID = RK_W'((N - 1) / 2);

	temp_t win_q [N];
	logic [N-1:0] wvld_q;
	temp_t nxt [N];

	temp_t w_s1 [N];
	logic [N-1:0] lt_s1 [N];
	logic full_s1;
	logic v_s1;

	med_beat_t beat_s2;
	logic v_s2;

	logic adv2;
	logic take;
	logic [N-1:0] lt [N];
	temp_t med;

	assign adv2 = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv2;
	assign take = in_valid && in_ready;

	always_comb begin
		nxt[0] = sample;
		for (int i = 1; i < N; i++) begin
			nxt[i] = win_q[i-1];
		end
	end

	// Ties are broken by tap position so that the ranks form a permutation.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				lt[i][j] = (nxt[j] < nxt[i]) || ((nxt[j] == nxt[i]) && (j < i));
			end
		end
	end

	always_comb begin
		med = w_s1[0];
		for (int i = 0; i < N; i++) begin
			if (RK_W'($countones(lt_s1[i])) == MID) begin
				med = w_s1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				wvld_q <= {wvld_q[N-2:0], 1'b1};
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			win_q <= nxt;
			w_s1 <= nxt;
			lt_s1 <= lt;
			full_s1 <= wvld_q[N-2];
		end
		if (v_s1 && adv2) begin
			beat_s2.mvalid <= full_s1;
			beat_s2.median <= med;
			beat_s2.sample <= w_s1[0];
		end
	end

	assign out_valid = v_s2;
	assign out_beat = beat_s2;

endmodule
